### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the insertion sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

### hw/rtl/isort_pkg.sv
// Package with types and constants of the insertion sorter.
`default_nettype none

package isort_pkg;

   localparam int DATA_W       = 32;
   localparam int CAPACITY_DEF = 16;

   // Input item payload.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   // Result item payload.
   typedef struct packed {
      logic signed [DATA_W-1:0] value_res;
      logic                     last_res;
      logic                     overflow;
   } rsp_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic drain;
   } ctrl_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic                     valid;
      logic                     gt;
      logic signed [DATA_W-1:0] value;
   } link_type;

endpackage

`default_nettype wire

### hw/rtl/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
`default_nettype none

module isort_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire isort_pkg::ctrl_type                  ctrl,
   input  wire logic signed [isort_pkg::DATA_W-1:0]  new_value,
   input  wire isort_pkg::link_type                  left,
   input  wire isort_pkg::link_type                  right,
   output isort_pkg::link_type                       link
);
   import isort_pkg::*;

   logic                     valid_ff;
   logic                     valid_in;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     gt;
   logic                     take;

   // Stored value lies strictly above the new one: it must move right.
   assign gt   = valid_ff && (value_ff > new_value);
   assign take = gt || (!valid_ff && left.valid);

   // Pick next content: insert shifts right, drain shifts left.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.drain) begin
         valid_in = right.valid;
         value_in = right.value;
      end else if (ctrl.insert && take) begin
         valid_in = 1'b1;
         value_in = left.gt ? left.value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.gt    = gt;
   assign link.value = value_ff;

endmodule

`default_nettype wire

### hw/rtl/insertion_sorter_unit.sv
// Top level of the streaming insertion sorter: cell chain and drain control.
//
// Usage: drive req_data and raise start; the item is taken at a rising edge
// where start is high and busy is low. Each value is inserted into a chain
// of CAPACITY cells that keeps the set in stable ascending order (an equal
// value lands after the stored ones). A non-last item leaves busy low, so
// values stream in at one per cycle while busy is low. Once the store is
// full, further values are dropped and every result of that set carries
// overflow. An item with last set is inserted (or dropped), then the chain
// shifts its content out of cell 0 one value per cycle, with busy high until
// the final stored value has left. The accepted last item sets the draining
// register, which then loads the result register and its strobe from
// cell 0; the rest follow one per cycle, the final one with last_res.
// Results show on rsp_data for one cycle with rsp_strobe; the receiver
// cannot stall. Reset empties the chain and clears the overflow mark; it
// takes effect at the next edge and needs no clearing pass.
`default_nettype none

module insertion_sorter_unit #(
   parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire isort_pkg::req_type   req_data,
   output logic                      rsp_strobe,
   output isort_pkg::rsp_type        rsp_data
);
   import isort_pkg::*;

   `include "assert_macros.svh"

   logic                draining_ff;
   logic                draining_in;
   logic                dropped_ff;
   logic                dropped_in;
   logic                rsp_strobe_ff;
   logic                rsp_strobe_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                accept;
   logic                full;
   ctrl_type            ctrl;
   link_type            links [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;

   assign accept = start && !busy;
   assign busy   = draining_ff;
   assign full   = links[CAPACITY-1].valid;

   // Broadcast the command to the chain.
   assign ctrl.insert = accept && !full;
   assign ctrl.drain  = draining_ff;

   // Build the chain of cells.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      link_type left_l;
      link_type right_l;

      if (i == 0) begin : g_head
         assign left_l = '{valid: 1'b1, gt: 1'b0, value: '0};
      end else begin : g_left
         assign left_l = links[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_l = '{valid: 1'b0, gt: 1'b0, value: '0};
      end else begin : g_right
         assign right_l = links[i+1];
      end

      isort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_value (req_data.value),
         .left      (left_l),
         .right     (right_l),
         .link      (links[i])
      );

      assign valid_vec[i] = links[i].valid;
   end

   // Track overflow, start and stop the drain, and load the result register.
   always_comb begin
      draining_in   = draining_ff;
      dropped_in    = dropped_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (draining_ff) begin
         rsp_strobe_in    = 1'b1;
         rsp_in.value_res = links[0].value;
         rsp_in.last_res  = !links[1].valid;
         rsp_in.overflow  = dropped_ff;
         if (!links[1].valid) begin
            draining_in = 1'b0;
            dropped_in  = 1'b0;
         end
      end else if (accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end
         draining_in = req_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff   <= 1'b0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         draining_ff   <= draining_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Valid cells always form a prefix of the chain.
   `ASSERT_PROP(a_valid_prefix, clock, reset, $onehot({1'b0, valid_vec} + 1'b1))
   // A drain never runs over an empty head cell.
   `ASSERT_NEVER(a_drain_empty, clock, reset, draining_ff && !links[0].valid)
   // The final result of a set is never followed directly by another result.
   `ASSERT_PROP(a_gap_after_last, clock, reset,
      (rsp_strobe && rsp_data.last_res) |=> !rsp_strobe)
   // A non-last item leaves the block ready for the next one.
   `ASSERT_PROP(a_stream_ready, clock, reset, (accept && !req_data.last) |=> !busy)

endmodule

`default_nettype wire
